[design/bshm_pkg.sv]
// ----------------------------------------------------------------------------
// bshm_pkg
// shared types and constants of the bucketed sorted hash map
// ----------------------------------------------------------------------------
package bshm_pkg;

  localparam int KEY_W        = 31;
  localparam int VAL_W        = 32;
  localparam int BUCKETS_DEF  = 256;
  localparam int SLOTS_DEF    = 16;
  // key bits folded into the bucket remainder per cycle
  localparam int HASH_DIGIT_W = 4;

  typedef enum logic {
    REQ_ADD    = 1'b0,
    REQ_SEARCH = 1'b1
  } req_t;

  typedef logic        [KEY_W-1:0] key_t;
  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    key_t key;
    val_t value;
  } slot_t;

endpackage

[design/bshm_if.sv]
// ----------------------------------------------------------------------------
// bshm request and result channels
// valid/ready channels carrying one request or one result per beat
// ----------------------------------------------------------------------------
interface bshm_in_if;
  logic               valid;
  logic               ready;
  bshm_pkg::req_t     req_type;
  bshm_pkg::key_t     key;
  bshm_pkg::val_t     value;

  modport source (output valid, output req_type, output key, output value, input ready);
  modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface bshm_out_if;
  logic               valid;
  logic               ready;
  bshm_pkg::val_t     found_value;
  logic               hit;
  logic               dropped;

  modport source (output valid, output found_value, output hit, output dropped, input ready);
  modport sink   (input valid, input found_value, input hit, input dropped, output ready);
endinterface

[design/bucketed_sorted_hash_map.sv]
// ----------------------------------------------------------------------------
// bucketed_sorted_hash_map
// key/value map with per-bucket sorted storage and binary-search lookup
// ----------------------------------------------------------------------------
// A key picks bucket key mod BUCKETS. An add appends the pair at the end of its
// bucket (keys are expected in ascending order per bucket, not checked) or is
// answered with dropped when the bucket already holds SLOTS_PER_BUCKET pairs.
// A search runs a binary search (low 0, high fill-1, floored midpoint) over
// the bucket and returns the value with hit, or 0 with hit low. Every request
// gives exactly one result beat. One request is worked on at a time. After
// the request beat, an add reads the bucket fill, writes back and hands its
// result over; a search reads the fill and then makes at most
// ceil(log2(SLOTS_PER_BUCKET+1)) probes; one probe per cycle is set by the
// registered read of the slot memory. When BUCKETS is not a power of two the
// bucket remainder is first worked out 4 key bits a cycle. After reset a
// clearing pass empties the fill memory, one bucket a cycle, before the first
// request is taken. A result waiting in the output register does not hold
// off the next request.
// ----------------------------------------------------------------------------
module bucketed_sorted_hash_map #(
  parameter int BUCKETS          = bshm_pkg::BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = bshm_pkg::SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bshm_in_if.sink      in_chan,
  bshm_out_if.source   out_chan
);

  // widths of bucket index, fill count and slot address
  localparam int BW     = $clog2(BUCKETS);
  localparam int FW     = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int TOTAL  = BUCKETS * SLOTS_PER_BUCKET;
  localparam int AW     = $clog2(TOTAL);
  localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  // remainder unit: key padded to whole digits
  localparam int DIG    = bshm_pkg::HASH_DIGIT_W;
  localparam int HSTEPS = (bshm_pkg::KEY_W + DIG - 1) / DIG;
  localparam int HKW    = HSTEPS * DIG;
  localparam int HCW    = (HSTEPS > 1) ? $clog2(HSTEPS) : 1;

  localparam logic [FW-1:0]  SLOTS_F   = FW'(SLOTS_PER_BUCKET);
  localparam logic [BW:0]    BUCKETS_R = (BW + 1)'(BUCKETS);
  localparam logic [BW-1:0]  LAST_BKT  = BW'(BUCKETS - 1);
  localparam logic [HCW-1:0] LAST_STEP = HCW'(HSTEPS - 1);
  localparam logic [AW-1:0]  SLOTS_A   = AW'(SLOTS_PER_BUCKET);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,  // sweep fill memory to zero
    ST_IDLE   = 7'b0000010,  // take a request
    ST_HASH   = 7'b0000100,  // fold key digits into bucket remainder
    ST_FILL   = 7'b0001000,  // read bucket fill, form slot base
    ST_DECIDE = 7'b0010000,  // add: write back; search: first probe
    ST_SEARCH = 7'b0100000,  // one probe compare per cycle
    ST_RESP   = 7'b1000000   // hand result to output register
  } state_t;

  // ---------------------------------------------------------------------------
  // memories: fill count per bucket and key/value per slot
  // ---------------------------------------------------------------------------
  logic [FW-1:0]       fill_mem [BUCKETS];
  bshm_pkg::slot_t     slot_mem [TOTAL];

  logic                fill_we;
  logic [BW-1:0]       fill_wa;
  logic [FW-1:0]       fill_wd;
  logic [FW-1:0]       fill_rd_r;

  logic                slot_we;
  logic [AW-1:0]       slot_wa;
  bshm_pkg::slot_t     slot_wd;
  logic [AW-1:0]       slot_ra;
  bshm_pkg::slot_t     slot_rd_r;

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  state_t              state_r,     state_nxt;
  logic [BW-1:0]       clr_idx_r,   clr_idx_nxt;
  bshm_pkg::req_t      req_r,       req_nxt;
  bshm_pkg::key_t      key_r,       key_nxt;
  bshm_pkg::val_t      value_r,     value_nxt;
  logic [HKW-1:0]      hkey_r,      hkey_nxt;
  logic [HCW-1:0]      hstep_r,     hstep_nxt;
  logic [BW-1:0]       bucket_r,    bucket_nxt;
  logic [AW-1:0]       base_r,      base_nxt;
  logic [FW-1:0]       low_r,       low_nxt;
  logic [FW-1:0]       hi_r,        hi_nxt;      // exclusive upper bound
  bshm_pkg::val_t      res_val_r,   res_val_nxt;
  logic                res_hit_r,   res_hit_nxt;
  logic                res_drop_r,  res_drop_nxt;
  bshm_pkg::val_t      out_val_r,   out_val_nxt;
  logic                out_hit_r,   out_hit_nxt;
  logic                out_drop_r,  out_drop_nxt;
  logic                out_valid_r, out_valid_nxt;

  // floored midpoint of [low, hi-1]; hi > low holds wherever it is used
  function automatic logic [FW-1:0] mid_of(input logic [FW-1:0] lo, input logic [FW-1:0] hi);
    logic [FW:0] sum;
    sum = {1'b0, lo} + {1'b0, hi} - (FW + 1)'(1);
    return sum[FW:1];
  endfunction

  // one cycle of the remainder unit: DIG restoring steps
  logic [BW:0]   rem_w;
  logic [BW-1:0] hash_rem;

  always_comb begin
    rem_w = {1'b0, bucket_r};
    for (int i = 0; i < DIG; i++) begin
      rem_w = {rem_w[BW-1:0], hkey_r[HKW-1-i]};
      if (rem_w >= BUCKETS_R) begin
        rem_w = rem_w - BUCKETS_R;
      end
    end
    hash_rem = rem_w[BW-1:0];
  end

  // probe bookkeeping
  logic [FW-1:0] cur_mid;
  logic [FW-1:0] probe_low;
  logic [FW-1:0] probe_hi;

  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.found_value = out_val_r;
  assign out_chan.hit         = out_hit_r;
  assign out_chan.dropped     = out_drop_r;
  assign cur_mid              = mid_of(low_r, hi_r);

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    value_nxt     = value_r;
    hkey_nxt      = hkey_r;
    hstep_nxt     = hstep_r;
    bucket_nxt    = bucket_r;
    base_nxt      = base_r;
    low_nxt       = low_r;
    hi_nxt        = hi_r;
    res_val_nxt   = res_val_r;
    res_hit_nxt   = res_hit_r;
    res_drop_nxt  = res_drop_r;
    out_val_nxt   = out_val_r;
    out_hit_nxt   = out_hit_r;
    out_drop_nxt  = out_drop_r;
    out_valid_nxt = out_valid_r;

    fill_we   = 1'b0;
    fill_wa   = bucket_r;
    fill_wd   = fill_rd_r + FW'(1);
    slot_we   = 1'b0;
    slot_wa   = base_r + AW'(fill_rd_r);
    slot_wd   = '{key: key_r, value: value_r};
    slot_ra   = base_r + AW'(cur_mid);
    probe_low = low_r;
    probe_hi  = hi_r;

    // output register drains independently of the request side
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        fill_we     = 1'b1;
        fill_wa     = clr_idx_r;
        fill_wd     = '0;
        clr_idx_nxt = clr_idx_r + BW'(1);
        if (clr_idx_r == LAST_BKT) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_chan.valid) begin
          req_nxt    = in_chan.req_type;
          key_nxt    = in_chan.key;
          value_nxt  = in_chan.value;
          hkey_nxt   = HKW'(in_chan.key);
          hstep_nxt  = '0;
          if (IS_POW2) begin
            // power-of-two bucket count: remainder is the low key bits
            bucket_nxt = in_chan.key[BW-1:0];
            state_nxt  = ST_FILL;
          end else begin
            bucket_nxt = '0;
            state_nxt  = ST_HASH;
          end
        end
      end

      ST_HASH: begin
        bucket_nxt = hash_rem;
        hkey_nxt   = hkey_r << DIG;
        hstep_nxt  = hstep_r + HCW'(1);
        if (hstep_r == LAST_STEP) begin
          state_nxt = ST_FILL;
        end
      end

      ST_FILL: begin
        // fill memory read of bucket_r lands in fill_rd_r next cycle
        base_nxt  = AW'(bucket_r) * SLOTS_A;
        state_nxt = ST_DECIDE;
      end

      ST_DECIDE: begin
        res_val_nxt  = '0;
        res_hit_nxt  = 1'b0;
        res_drop_nxt = 1'b0;
        if (req_r == bshm_pkg::REQ_ADD) begin
          if (fill_rd_r == SLOTS_F) begin
            // bucket full, pair discarded
            res_drop_nxt = 1'b1;
          end else begin
            slot_we = 1'b1;
            fill_we = 1'b1;
          end
          state_nxt = ST_RESP;
        end else if (fill_rd_r == '0) begin
          // empty bucket misses at once
          state_nxt = ST_RESP;
        end else begin
          probe_low = '0;
          probe_hi  = fill_rd_r;
          slot_ra   = base_r + AW'(mid_of(probe_low, probe_hi));
          low_nxt   = probe_low;
          hi_nxt    = probe_hi;
          state_nxt = ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        if (slot_rd_r.key == key_r) begin
          res_val_nxt = slot_rd_r.value;
          res_hit_nxt = 1'b1;
          state_nxt   = ST_RESP;
        end else begin
          if (slot_rd_r.key > key_r) begin
            probe_hi = cur_mid;
          end else begin
            probe_low = cur_mid + FW'(1);
          end
          low_nxt = probe_low;
          hi_nxt  = probe_hi;
          if (probe_low < probe_hi) begin
            // next probe issued the same cycle
            slot_ra = base_r + AW'(mid_of(probe_low, probe_hi));
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        if (!out_valid_r || out_chan.ready) begin
          out_val_nxt   = res_val_r;
          out_hit_nxt   = res_hit_r;
          out_drop_nxt  = res_drop_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    key_r      <= key_nxt;
    value_r    <= value_nxt;
    hkey_r     <= hkey_nxt;
    hstep_r    <= hstep_nxt;
    bucket_r   <= bucket_nxt;
    base_r     <= base_nxt;
    low_r      <= low_nxt;
    hi_r       <= hi_nxt;
    res_val_r  <= res_val_nxt;
    res_hit_r  <= res_hit_nxt;
    res_drop_r <= res_drop_nxt;
    out_val_r  <= out_val_nxt;
    out_hit_r  <= out_hit_nxt;
    out_drop_r <= out_drop_nxt;
  end

  // fill memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_wa] <= fill_wd;
    end
    fill_rd_r <= fill_mem[bucket_r];
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd_r <= slot_mem[slot_ra];
  end

endmodule
